/* hw/rtl/mts_pkg.sv */
package mts_pkg;

    // Tree geometry: LEAVES must be a power of two
    localparam int LEAVES  = 1024;
    localparam int LEVELS  = $clog2(LEAVES);
    localparam int LEAF_W  = LEVELS;
    localparam int NODE_AW = LEVELS + 1;
    localparam int NODES   = 2 * LEAVES;

    // Field widths
    localparam int VAL_W  = 32;
    localparam int POS_W  = 10;
    localparam int SIZE_W = 11;

    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(1024);
    localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

    // Action codes
    localparam logic ACT_ASSIGN = 1'b0;
    localparam logic ACT_FIND   = 1'b1;

    // Search result handed from the sequencer to the output stage
    typedef struct packed {
        logic              valid;
        logic              found;
        logic [LEAF_W-1:0] leaf;
    } res_t;

endpackage

/* hw/rtl/mts_ram.sv */
module mts_ram (
    input  logic                               clk,
    input  logic                               wr_en,
    input  logic [mts_pkg::NODE_AW-1:0]        wr_addr,
    input  logic signed [mts_pkg::VAL_W-1:0]   wr_data,
    input  logic                               rd_en,
    input  logic [mts_pkg::NODE_AW-1:0]        rd_addr,
    output logic signed [mts_pkg::VAL_W-1:0]   rd_data
);
    import mts_pkg::*;

    logic signed [VAL_W-1:0] mem [NODES];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* hw/rtl/mts_seq.sv */
module mts_seq (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               action,
    input  logic [mts_pkg::POS_W-1:0]          position,
    input  logic signed [mts_pkg::VAL_W-1:0]   value,
    output mts_pkg::res_t                      res,
    input  logic                               res_take
);
    import mts_pkg::*;

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_UP    = 6'b000100,
        S_FROOT = 6'b001000,
        S_FDOWN = 6'b010000,
        S_FIN   = 6'b100000
    } state_t;

    state_t                  state_reg, state_next;
    logic [NODE_AW-1:0]      node_reg, node_next;
    logic [NODE_AW-1:0]      clr_reg, clr_next;
    logic signed [VAL_W-1:0] val_reg, val_next;
    logic [LEAF_W-1:0]       leaf_reg, leaf_next;
    logic                    found_reg, found_next;

    logic                    wr_en, rd_en;
    logic [NODE_AW-1:0]      wr_addr, rd_addr;
    logic signed [VAL_W-1:0] wr_data, rd_data;

    logic signed [VAL_W-1:0] cmp_a, cmp_b;
    logic                    ge;
    logic [NODE_AW-1:0]      parent, down_node, leaf_addr;
    logic                    pos_ok;

    mts_ram u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Shared compare unit: running max on the way up, threshold test on the way down
    always_comb
    begin
        if (state_reg == S_UP)
        begin
            cmp_a = val_reg;
            cmp_b = rd_data;
        end
        else
        begin
            cmp_a = rd_data;
            cmp_b = val_reg;
        end
    end

    assign ge        = (cmp_a >= cmp_b);
    assign parent    = node_reg >> 1;
    assign down_node = ge ? node_reg : (node_reg | NODE_AW'(1));
    assign leaf_addr = NODE_AW'(LEAVES) + NODE_AW'(position);
    assign pos_ok    = (32'(position) < LEAVES);

    assign in_ready  = (state_reg == S_IDLE);
    assign res.valid = (state_reg == S_FIN);
    assign res.found = found_reg;
    assign res.leaf  = leaf_reg;

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        node_next  = node_reg;
        clr_next   = clr_reg;
        val_next   = val_reg;
        leaf_next  = leaf_reg;
        found_next = found_reg;
        wr_en      = 1'b0;
        wr_addr    = clr_reg;
        wr_data    = VAL_MIN;
        rd_en      = 1'b0;
        rd_addr    = node_reg;

        case (state_reg)
            S_CLEAR:
            begin
                // Sweep every node to the most negative value
                wr_en    = 1'b1;
                clr_next = clr_reg + NODE_AW'(1);
                if (&clr_reg)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    val_next = value;
                    if (action == ACT_FIND)
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = NODE_AW'(1);
                        state_next = S_FROOT;
                    end
                    else if (pos_ok)
                    begin
                        // Store the leaf and fetch its sibling
                        wr_en      = 1'b1;
                        wr_addr    = leaf_addr;
                        wr_data    = value;
                        rd_en      = 1'b1;
                        rd_addr    = leaf_addr ^ NODE_AW'(1);
                        node_next  = leaf_addr;
                        state_next = S_UP;
                    end
                end
            end
            S_UP:
            begin
                // Refresh the parent and, below the root, fetch the parent's sibling
                wr_en     = 1'b1;
                wr_addr   = parent;
                wr_data   = ge ? val_reg : rd_data;
                val_next  = wr_data;
                node_next = parent;
                if (parent == NODE_AW'(1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    rd_en   = 1'b1;
                    rd_addr = parent ^ NODE_AW'(1);
                end
            end
            S_FROOT:
            begin
                if (ge)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = NODE_AW'(2);
                    node_next  = NODE_AW'(2);
                    state_next = S_FDOWN;
                end
                else
                begin
                    found_next = 1'b0;
                    leaf_next  = '0;
                    state_next = S_FIN;
                end
            end
            S_FDOWN:
            begin
                // Take the left child if it qualifies, else the right one
                if (down_node[NODE_AW-1])
                begin
                    found_next = 1'b1;
                    leaf_next  = LEAF_W'(down_node - NODE_AW'(LEAVES));
                    state_next = S_FIN;
                end
                else
                begin
                    rd_en     = 1'b1;
                    rd_addr   = down_node << 1;
                    node_next = down_node << 1;
                end
            end
            S_FIN:
            begin
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        node_reg  <= node_next;
        val_reg   <= val_next;
        leaf_reg  <= leaf_next;
        found_reg <= found_next;
    end

`ifndef SYNTH
    a_no_write_in_find: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FROOT || state_reg == S_FDOWN) |-> !wr_en)
        else $error("tree written during a find");

    a_root_ends_update: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_UP && parent == NODE_AW'(1)) |=> (state_reg == S_IDLE))
        else $error("update did not stop at the root");

    a_fin_from_find: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(state_reg == S_FIN) |-> $past(state_reg == S_FROOT || state_reg == S_FDOWN))
        else $error("result raised outside a find");

    a_down_left_child: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FDOWN) |-> !node_reg[0])
        else $error("descent is not examining a left child");
`endif

endmodule

/* hw/rtl/max_tree_first_at_least_search_unit.sv */
// Assign transaction: in_ready returns after the leaf write and the climb to the root (one
// tree level per cycle through the shared compare unit); assigns are accepted one at a time.
// Find transaction: root check, descent through ten levels if the root qualifies, then hand-off;
// the next transaction is accepted only after the hand-off; a stalled result holds the sequencer.
// Reset: asynchronous, active low; then a clearing pass over all 2048 nodes of the node memory
// with in_ready low; size_in_use resets to 1024.
module max_tree_first_at_least_search_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               action,
    input  logic [mts_pkg::POS_W-1:0]          position,
    input  logic signed [mts_pkg::VAL_W-1:0]   value,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic                               found,
    output logic [mts_pkg::POS_W-1:0]          first_position,
    input  logic                               cfg_we,
    input  logic [mts_pkg::SIZE_W-1:0]         cfg_data
);
    import mts_pkg::*;

    res_t              res;
    logic              res_take;
    logic              hit_ok;
    logic [SIZE_W-1:0] size_reg;
    logic              out_valid_reg, out_valid_next;
    logic              found_reg;
    logic [POS_W-1:0]  pos_reg;

    mts_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .action   (action),
        .position (position),
        .value    (value),
        .res      (res),
        .res_take (res_take)
    );

    // Take a result when the output slot is empty or draining
    assign res_take = res.valid && (!out_valid_reg || out_ready);
    assign hit_ok   = res.found && (32'(res.leaf) < 32'(size_reg));

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (res_take)
        begin
            out_valid_next = 1'b1;
        end
    end

    // Configuration and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg      <= SIZE_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                size_reg <= cfg_data;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload: drop matches beyond the size in use
    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            found_reg <= hit_ok;
            pos_reg   <= hit_ok ? POS_W'(res.leaf) : '0;
        end
    end

    assign out_valid      = out_valid_reg;
    assign found          = found_reg;
    assign first_position = pos_reg;

endmodule
